// ----- hw/rtl/ioac_pkg.sv -----
// ----------------------------------------------------------------------------
// ioac_pkg
// Shared constants, codes, command structs and helpers of the address cache.
// ----------------------------------------------------------------------------
package ioac_pkg;

   localparam int DEPTH      = 32;
   localparam int HBINS      = 32;
   localparam int LIM_CAP    = (DEPTH < HBINS) ? DEPTH : HBINS;
   localparam int SLOT_AW    = $clog2(DEPTH);
   localparam int TAG_AW     = SLOT_AW + 1;
   localparam int TAG_N      = 2 * DEPTH;
   localparam int TAG_W      = 128;
   localparam int BIN_AW     = $clog2(HBINS);
   localparam int HIST_AW    = BIN_AW + 1;
   localparam int HIST_N     = 2 * HBINS;
   localparam int CNT_W      = 6;
   localparam int STAT_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;

   localparam logic [CNT_W-1:0] LIMIT_RESET = 6'd20;

   localparam logic [2:0] ST_IGNORED  = 3'd0;
   localparam logic [2:0] ST_HIT      = 3'd1;
   localparam logic [2:0] ST_MISS_INS = 3'd2;
   localparam logic [2:0] ST_MISS_UNC = 3'd3;
   localparam logic [2:0] ST_STATS    = 3'd4;

   localparam logic REQ_LOOKUP = 1'b0;
   localparam logic REQ_STATS  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_MODULE_EN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CACHE_EN    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_LIMIT = 2'd2;

   typedef struct packed {
      logic              we;
      logic [TAG_AW-1:0] waddr;
      logic [TAG_AW-1:0] raddr;
      logic              v4;
   } tag_cmd_type;

   typedef struct packed {
      logic               we;
      logic [HIST_AW-1:0] addr;
      logic [STAT_W-1:0]  wdata;
   } hist_cmd_type;

   function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

endpackage

// ----- hw/rtl/ioac_req_if.sv -----
// ----------------------------------------------------------------------------
// ioac_req_if
// Request channel: valid/ready handshake with the lookup or statistics item.
// ----------------------------------------------------------------------------
interface ioac_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [1:0]  family;
   logic [63:0] addr_high;
   logic [63:0] addr_low;
   logic [4:0]  stat_index;

   modport source (output valid, req_type, family, addr_high, addr_low, stat_index,
                   input ready);
   modport sink (input valid, req_type, family, addr_high, addr_low, stat_index,
                 output ready);
endinterface

// ----- hw/rtl/ioac_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ioac_rsp_if
// Response channel: valid/ready handshake with the result item.
// ----------------------------------------------------------------------------
interface ioac_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [4:0]  slot;
   logic [4:0]  distance;
   logic [31:0] bin_count;
   logic [31:0] lookup_count;

   modport source (output valid, status, slot, distance, bin_count, lookup_count,
                   input ready);
   modport sink (input valid, status, slot, distance, bin_count, lookup_count,
                 output ready);
endinterface

// ----- hw/rtl/ioac_tag_store.sv -----
// ----------------------------------------------------------------------------
// ioac_tag_store
// Tag memory for both families with registered read and the shared comparator.
// ----------------------------------------------------------------------------
module ioac_tag_store (
   input  logic                       clock,
   input  ioac_pkg::tag_cmd_type      cmd,
   input  logic [ioac_pkg::TAG_W-1:0] wdata,
   input  logic [ioac_pkg::TAG_W-1:0] key,
   output logic                       match
);
   import ioac_pkg::*;

   logic [TAG_W-1:0] mem [0:TAG_N-1];
   logic [TAG_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[cmd.waddr] <= wdata;
      end
      rdata_ff <= mem[cmd.raddr];
   end

   // IPv4 tags live in the low 32 bits; ignore the rest
   assign match = cmd.v4 ? (rdata_ff[31:0] == key[31:0]) : (rdata_ff == key);

endmodule

// ----- hw/rtl/ioac_hist_ram.sv -----
// ----------------------------------------------------------------------------
// ioac_hist_ram
// Hit distance histogram memory; entries read as zero until first written.
// ----------------------------------------------------------------------------
module ioac_hist_ram (
   input  logic                        clock,
   input  logic                        reset,
   input  ioac_pkg::hist_cmd_type      cmd,
   output logic [ioac_pkg::STAT_W-1:0] rdata
);
   import ioac_pkg::*;

   logic [STAT_W-1:0] mem [0:HIST_N-1];
   logic [STAT_W-1:0] data_ff;
   logic [HIST_N-1:0] vld_ff;
   logic [HIST_N-1:0] vld_in;
   logic              rd_vld_ff;

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[cmd.addr] <= cmd.wdata;
      end
      data_ff <= mem[cmd.addr];
   end

   always_comb begin
      vld_in = vld_ff;
      if (cmd.we) begin
         vld_in[cmd.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         vld_ff    <= vld_in;
         rd_vld_ff <= vld_ff[cmd.addr];
      end
   end

   assign rdata = rd_vld_ff ? data_ff : '0;

endmodule

// ----- hw/rtl/insertion_order_address_cache.sv -----
// ----------------------------------------------------------------------------
// insertion_order_address_cache: one item at a time; a lookup runs one tag
// compare per cycle through the tag memory over the filled slots.
// Synchronous reset clears registers, counters, fill state and histogram.
// ----------------------------------------------------------------------------
module insertion_order_address_cache (
   input  logic                           clock,
   input  logic                           reset,
   ioac_req_if.sink                       req_ch,
   ioac_rsp_if.source                     rsp_ch,
   input  logic                           csr_we,
   input  logic [ioac_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ioac_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ioac_pkg::*;

   // Sequencer codes
   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SEARCH   = 3'd1;
   localparam logic [2:0] S_INSERT   = 3'd2;
   localparam logic [2:0] S_HIST_RD  = 3'd3;
   localparam logic [2:0] S_HIST_WR  = 3'd4;
   localparam logic [2:0] S_STAT_RD  = 3'd5;
   localparam logic [2:0] S_STAT_OUT = 3'd6;
   localparam logic [2:0] S_DONE     = 3'd7;

   logic [2:0] state_ff, state_in;

   // Configuration registers
   logic             module_en_ff, module_en_in;
   logic             cache_en_ff, cache_en_in;
   logic [CNT_W-1:0] limit_ff, limit_in;

   // Per-family ring state and search counters
   logic [CNT_W-1:0]  fill_ff [2];
   logic [CNT_W-1:0]  fill_in [2];
   logic [CNT_W-1:0]  newest_ff [2];
   logic [CNT_W-1:0]  newest_in [2];
   logic [STAT_W-1:0] searches_ff [2];
   logic [STAT_W-1:0] searches_in [2];

   // Latched item and its ring snapshot
   logic              fam_ff, fam_in;
   logic [63:0]       hi_ff, hi_in;
   logic [63:0]       lo_ff, lo_in;
   logic [BIN_AW-1:0] sidx_ff, sidx_in;
   logic [CNT_W-1:0]  f_ff, f_in;
   logic [CNT_W-1:0]  n_ff, n_in;

   // Search walk: issue pointer and the compare stage registered behind it
   logic [CNT_W-1:0]   k_ff, k_in;
   logic               cmp_valid_ff, cmp_valid_in;
   logic [BIN_AW-1:0]  cmp_k_ff, cmp_k_in;
   logic [SLOT_AW-1:0] cmp_slot_ff, cmp_slot_in;

   // Finished result waiting for the output register
   logic [2:0]        res_status_ff, res_status_in;
   logic [4:0]        res_slot_ff, res_slot_in;
   logic [4:0]        res_dist_ff, res_dist_in;
   logic [STAT_W-1:0] res_bin_ff, res_bin_in;
   logic [STAT_W-1:0] res_lookup_ff, res_lookup_in;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_status_ff, rsp_status_in;
   logic [4:0]        rsp_slot_ff, rsp_slot_in;
   logic [4:0]        rsp_dist_ff, rsp_dist_in;
   logic [STAT_W-1:0] rsp_bin_ff, rsp_bin_in;
   logic [STAT_W-1:0] rsp_lookup_ff, rsp_lookup_in;

   tag_cmd_type       tag_cmd;
   hist_cmd_type      hist_cmd;
   logic              tag_match;
   logic [STAT_W-1:0] hist_rdata;

   logic             req_take;
   logic             issue;
   logic [CNT_W-1:0] walk_slot;
   logic [CNT_W-1:0] lim;
   logic [CNT_W-1:0] new_n;
   logic [CNT_W-1:0] ins_slot;

   ioac_tag_store u_tags (
      .clock (clock),
      .cmd   (tag_cmd),
      .wdata ({hi_ff, lo_ff}),
      .key   ({hi_ff, lo_ff}),
      .match (tag_match)
   );

   ioac_hist_ram u_hist (
      .clock (clock),
      .reset (reset),
      .cmd   (hist_cmd),
      .rdata (hist_rdata)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;

   // Effective ring size: at least one, at most the tag depth and bin count
   assign lim = (limit_ff == '0) ? CNT_W'(1) :
                (limit_ff > CNT_W'(LIM_CAP)) ? CNT_W'(LIM_CAP) : limit_ff;

   // Walk order: newest back to slot 0, then top filled slot down past newest
   assign walk_slot = (k_ff < n_ff) ? (n_ff - CNT_W'(1) - k_ff)
                                    : (f_ff + n_ff - CNT_W'(1) - k_ff);

   // Next insert position; wrap once the position reaches the limit
   always_comb begin
      if (f_ff < lim) begin
         new_n = n_ff + CNT_W'(1);
      end else if (n_ff >= lim) begin
         new_n = CNT_W'(1);
      end else begin
         new_n = n_ff + CNT_W'(1);
      end
   end
   assign ins_slot = new_n - CNT_W'(1);

   assign issue = (state_ff == S_SEARCH) && (k_ff < f_ff);

   always_comb begin
      tag_cmd.we    = (state_ff == S_INSERT);
      tag_cmd.waddr = {fam_ff, ins_slot[SLOT_AW-1:0]};
      tag_cmd.raddr = {fam_ff, walk_slot[SLOT_AW-1:0]};
      tag_cmd.v4    = ~fam_ff;
   end

   always_comb begin
      hist_cmd.we    = (state_ff == S_HIST_WR);
      hist_cmd.wdata = sat_inc(hist_rdata);
      if (state_ff == S_HIST_RD || state_ff == S_HIST_WR) begin
         hist_cmd.addr = {fam_ff, res_dist_ff[BIN_AW-1:0]};
      end else begin
         hist_cmd.addr = {fam_ff, sidx_ff};
      end
   end

   always_comb begin
      state_in      = state_ff;
      module_en_in  = module_en_ff;
      cache_en_in   = cache_en_ff;
      limit_in      = limit_ff;
      fill_in       = fill_ff;
      newest_in     = newest_ff;
      searches_in   = searches_ff;
      fam_in        = fam_ff;
      hi_in         = hi_ff;
      lo_in         = lo_ff;
      sidx_in       = sidx_ff;
      f_in          = f_ff;
      n_in          = n_ff;
      k_in          = k_ff;
      cmp_valid_in  = 1'b0;
      cmp_k_in      = k_ff[BIN_AW-1:0];
      cmp_slot_in   = walk_slot[SLOT_AW-1:0];
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_dist_in   = res_dist_ff;
      res_bin_in    = res_bin_ff;
      res_lookup_in = res_lookup_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_bin_in    = rsp_bin_ff;
      rsp_lookup_in = rsp_lookup_ff;

      // Configuration writes must arrive only while idle; the block itself does not enforce this
      if (csr_we) begin
         unique case (csr_index)
            CSR_MODULE_EN:   module_en_in = csr_wdata[0];
            CSR_CACHE_EN:    cache_en_in  = csr_wdata[0];
            CSR_ENTRY_LIMIT: limit_in     = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               fam_in        = req_ch.family[0];
               hi_in         = req_ch.addr_high;
               lo_in         = req_ch.addr_low;
               sidx_in       = req_ch.stat_index;
               f_in          = fill_ff[req_ch.family[0]];
               n_in          = newest_ff[req_ch.family[0]];
               k_in          = '0;
               res_slot_in   = '0;
               res_dist_in   = '0;
               res_bin_in    = '0;
               res_lookup_in = '0;
               if (req_ch.req_type == REQ_STATS) begin
                  res_status_in = ST_STATS;
                  // Unsupported family answers with zero counts
                  state_in = req_ch.family[1] ? S_DONE : S_STAT_RD;
               end else if (!module_en_ff || req_ch.family[1]) begin
                  res_status_in = ST_IGNORED;
                  state_in      = S_DONE;
               end else if (!cache_en_ff) begin
                  res_status_in = ST_MISS_UNC;
                  state_in      = S_DONE;
               end else if (fill_ff[req_ch.family[0]] == '0) begin
                  // Empty ring: insert without a search
                  state_in = S_INSERT;
               end else begin
                  searches_in[req_ch.family[0]] = sat_inc(searches_ff[req_ch.family[0]]);
                  state_in = S_SEARCH;
               end
            end
         end
         S_SEARCH: begin
            if (cmp_valid_ff && tag_match) begin
               res_status_in = ST_HIT;
               res_slot_in   = 5'(cmp_slot_ff);
               res_dist_in   = 5'(cmp_k_ff);
               state_in      = S_HIST_RD;
            end else if (cmp_valid_ff && ({1'b0, cmp_k_ff} == f_ff - CNT_W'(1))) begin
               state_in = S_INSERT;
            end else begin
               // Advance the walk: issue a read now, compare it next cycle
               cmp_valid_in = issue;
               if (issue) begin
                  k_in = k_ff + CNT_W'(1);
               end
            end
         end
         S_INSERT: begin
            newest_in[fam_ff] = new_n;
            if (f_ff < lim) begin
               fill_in[fam_ff] = f_ff + CNT_W'(1);
            end
            res_status_in = ST_MISS_INS;
            res_slot_in   = ins_slot[4:0];
            state_in      = S_DONE;
         end
         S_HIST_RD: begin
            state_in = S_HIST_WR;
         end
         S_HIST_WR: begin
            state_in = S_DONE;
         end
         S_STAT_RD: begin
            state_in = S_STAT_OUT;
         end
         S_STAT_OUT: begin
            res_bin_in    = hist_rdata;
            res_lookup_in = searches_ff[fam_ff];
            state_in      = S_DONE;
         end
         S_DONE: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_dist_in   = res_dist_ff;
               rsp_bin_in    = res_bin_ff;
               rsp_lookup_in = res_lookup_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         module_en_ff <= 1'b0;
         cache_en_ff  <= 1'b1;
         limit_ff     <= LIMIT_RESET;
         fill_ff      <= '{default: '0};
         newest_ff    <= '{default: '0};
         searches_ff  <= '{default: '0};
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         module_en_ff <= module_en_in;
         cache_en_ff  <= cache_en_in;
         limit_ff     <= limit_in;
         fill_ff      <= fill_in;
         newest_ff    <= newest_in;
         searches_ff  <= searches_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      fam_ff        <= fam_in;
      hi_ff         <= hi_in;
      lo_ff         <= lo_in;
      sidx_ff       <= sidx_in;
      f_ff          <= f_in;
      n_ff          <= n_in;
      k_ff          <= k_in;
      cmp_k_ff      <= cmp_k_in;
      cmp_slot_ff   <= cmp_slot_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_dist_ff   <= res_dist_in;
      res_bin_ff    <= res_bin_in;
      res_lookup_ff <= res_lookup_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_bin_ff    <= rsp_bin_in;
      rsp_lookup_ff <= rsp_lookup_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.slot         = rsp_slot_ff;
   assign rsp_ch.distance     = rsp_dist_ff;
   assign rsp_ch.bin_count    = rsp_bin_ff;
   assign rsp_ch.lookup_count = rsp_lookup_ff;

`ifndef SYNTHESIS
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> (k_ff <= f_ff))
      else $error("search walk passed the filled count");

   a_ring_v4: assert property (@(posedge clock) disable iff (reset)
      (newest_ff[0] <= fill_ff[0]) && (fill_ff[0] <= CNT_W'(LIM_CAP)))
      else $error("IPv4 ring position or fill out of range");

   a_ring_v6: assert property (@(posedge clock) disable iff (reset)
      (newest_ff[1] <= fill_ff[1]) && (fill_ff[1] <= CNT_W'(LIM_CAP)))
      else $error("IPv6 ring position or fill out of range");

   a_hit_counts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH && cmp_valid_ff && tag_match) |=> (state_ff == S_HIST_RD))
      else $error("hit did not go on to the histogram update");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("result raised outside the done step");
`endif

endmodule

// ----- bench/insertion_order_address_cache_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insertion_order_address_cache_tb
// Drives lookups and statistics reads into the address cache and checks every
// result against a predictor of the two per-family rings or a typed row. A
// directed table runs first, then random phases, each with its own settings.
// ----------------------------------------------------------------------------
module insertion_order_address_cache_tb;
   import ioac_pkg::*;

   // Address family codes of a request item
   localparam logic [1:0] FAM_V4  = 2'd0;
   localparam logic [1:0] FAM_V6  = 2'd1;
   localparam logic [1:0] FAM_BAD = 2'd2;
   localparam logic [1:0] FAM_RSV = 2'd3;

   localparam logic [63:0] ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;

   localparam int POOL_N       = 40;    // a bit more addresses than ring slots
   localparam int PHASES       = 7;
   localparam int PHASE_ITEMS  = 210;
   localparam int UNCACHED_ITEMS = 100;
   localparam int QUIET_LIMIT  = 1000;  // cycles without any handshake
   localparam int DRAIN_CYCLES = 40;    // longest search plus margin

   typedef struct packed {
      logic        req_type;
      logic [1:0]  family;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic [4:0]  stat_index;
   } cache_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [4:0]  slot;
      logic [4:0]  distance;
      logic [31:0] bin_count;
      logic [31:0] lookup_count;
   } cache_rsp_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type             kind;
      cache_req_type            rq;
      logic                     typed;   // expected result written in the row
      cache_rsp_type            want;
      logic [CSR_IDX_W-1:0]     idx;
      logic [CSR_DATA_W-1:0]    val;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ioac_req_if req_ch ();
   ioac_rsp_if rsp_ch ();

   insertion_order_address_cache u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Predictor state: a private copy of both rings, counters and registers
   // ---------------------------------------------------------------------
   logic [31:0] v4_tag_mem [DEPTH];
   logic [63:0] v6_hi_mem  [DEPTH];
   logic [63:0] v6_lo_mem  [DEPTH];
   int unsigned fill_cnt [2];
   int unsigned ins_pos  [2];     // newest slot plus one
   logic [31:0] hit_bins [2][HBINS];
   logic [31:0] search_cnt [2];
   logic        cfg_module_en;
   logic        cfg_cache_en;
   logic [5:0]  cfg_limit;

   // Address pools, so that random lookups revisit cached addresses
   logic [31:0] v4_pool    [POOL_N];
   logic [63:0] v6_pool_hi [POOL_N];
   logic [63:0] v6_pool_lo [POOL_N];

   cache_rsp_type pending_outcomes [$];
   stim_row_type  directed_rows [$];
   int unsigned lookups_sent;     // items accepted, owned by the sender
   int unsigned outcomes_seen;    // results accepted, updated at the edge
   int unsigned mismatches = 0;
   int unsigned quiet_cycles;
   int unsigned rsp_stall;
   logic        idling;

   // ---------------------------------------------------------------------
   // Clock
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Helpers
   // ---------------------------------------------------------------------
   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Ring size actually in use: zero counts as one, the top is capped
   function automatic int unsigned ring_size(input logic [5:0] v);
      if (v == 6'd0) return 1;
      if (v > LIM_CAP) return LIM_CAP;
      return v;
   endfunction

   // Raising the ring past the fill of a wrapped ring would count a slot as
   // filled that was never written; keep clear of that.
   function automatic logic limit_is_safe(input logic [5:0] v);
      int fam;
      for (fam = 0; fam < 2; fam++) begin
         if (ring_size(v) > fill_cnt[fam] && ins_pos[fam] != fill_cnt[fam])
            return 1'b0;
      end
      return 1'b1;
   endfunction

   // Expected result of one item; updates the predictor state as the block would
   function automatic cache_rsp_type cache_outcome(input cache_req_type rq);
      cache_rsp_type r;
      int unsigned   fam, newest, filled, lim, d, s;
      int            hit;
      r = '0;
      hit = -1;
      if (rq.req_type == REQ_STATS) begin
         r.status = ST_STATS;
         if (rq.family == FAM_V4 || rq.family == FAM_V6) begin
            r.bin_count    = hit_bins[rq.family[0]][rq.stat_index];
            r.lookup_count = search_cnt[rq.family[0]];
         end
         return r;
      end
      if (!cfg_module_en || !(rq.family == FAM_V4 || rq.family == FAM_V6))
         return r;
      if (!cfg_cache_en) begin
         r.status = ST_MISS_UNC;
         return r;
      end
      fam    = rq.family[0];
      newest = ins_pos[fam];
      filled = fill_cnt[fam];
      if (filled > 0) begin
         if (search_cnt[fam] != '1) search_cnt[fam] = search_cnt[fam] + 1;
         // newest first, back to slot 0, then down from the top filled slot
         for (d = 0; d < filled; d++) begin
            s = (d < newest) ? newest - 1 - d : filled - 1 - (d - newest);
            if (fam == 0 ? (v4_tag_mem[s] == rq.addr_low[31:0])
                         : (v6_hi_mem[s] == rq.addr_high &&
                            v6_lo_mem[s] == rq.addr_low)) begin
               hit = s;
               break;
            end
         end
         if (hit >= 0) begin
            if (hit_bins[fam][d[4:0]] != '1)
               hit_bins[fam][d[4:0]] = hit_bins[fam][d[4:0]] + 1;
            r.status   = ST_HIT;
            r.slot     = hit[4:0];
            r.distance = d[4:0];
            return r;
         end
      end
      // miss: advance the ring, wrap to slot 0 at the limit
      lim = ring_size(cfg_limit);
      if (filled < lim) begin
         ins_pos[fam]  = newest + 1;
         fill_cnt[fam] = filled + 1;
      end else if (newest >= lim) begin
         ins_pos[fam] = 1;
      end else begin
         ins_pos[fam] = newest + 1;
      end
      s = ins_pos[fam] - 1;
      if (fam == 0) begin
         v4_tag_mem[s] = rq.addr_low[31:0];
      end else begin
         v6_hi_mem[s] = rq.addr_high;
         v6_lo_mem[s] = rq.addr_low;
      end
      r.status = ST_MISS_INS;
      r.slot   = s[4:0];
      return r;
   endfunction

   // Table rows
   function automatic stim_row_type item_row(input logic rt, input logic [1:0] fam,
                                             input logic [63:0] hi, input logic [63:0] lo,
                                             input logic [4:0] sidx, input logic typed,
                                             input logic [2:0] st, input logic [4:0] sl,
                                             input logic [4:0] want_dist);
      stim_row_type r;
      r.kind          = ROW_ITEM;
      r.rq.req_type   = rt;
      r.rq.family     = fam;
      r.rq.addr_high  = hi;
      r.rq.addr_low   = lo;
      r.rq.stat_index = sidx;
      r.typed         = typed;
      r.want          = '0;
      r.want.status   = st;
      r.want.slot     = sl;
      r.want.distance = want_dist;
      r.idx           = '0;
      r.val           = '0;
      return r;
   endfunction

   function automatic stim_row_type csr_row(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] val);
      stim_row_type r;
      r.kind  = ROW_CSR;
      r.rq    = '0;
      r.typed = 1'b0;
      r.want  = '0;
      r.idx   = idx;
      r.val   = val;
      return r;
   endfunction

   // Random item: mostly pool addresses so that hits and evictions happen,
   // with near misses, fresh addresses and unsupported families as noise
   function automatic cache_req_type draw_request();
      cache_req_type rq;
      int unsigned   pick, k;
      logic [63:0]   hi, lo;
      rq.req_type   = ($urandom_range(0, 99) < 12) ? REQ_STATS : REQ_LOOKUP;
      rq.stat_index = 5'($urandom_range(0, 31));
      pick = $urandom_range(0, 99);
      if (pick < 45)      rq.family = FAM_V4;
      else if (pick < 90) rq.family = FAM_V6;
      else                rq.family = 2'($urandom_range(2, 3));
      k = $urandom_range(0, POOL_N - 1);
      if (rq.family == FAM_V4) begin
         // upper bits carry junk that the block must not look at
         hi = ($urandom_range(0, 3) == 0) ? rand64() : 64'd0;
         lo = {$urandom, ($urandom_range(0, 9) == 0) ? $urandom : v4_pool[k]};
      end else begin
         hi = v6_pool_hi[k];
         lo = v6_pool_lo[k];
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            hi = rand64();
            lo = rand64();
         end else if (pick == 1) begin
            hi = hi ^ (64'd1 << $urandom_range(0, 63));
         end else if (pick == 2) begin
            lo = lo ^ (64'd1 << $urandom_range(0, 63));
         end
      end
      rq.addr_high = hi;
      rq.addr_low  = lo;
      return rq;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: %s got %0h, expected %0h", $time, what, got, want);
      mismatches = mismatches + 1;
   endtask

   // Register write; only once the block has returned every result
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      req_ch.valid <= 1'b0;
      while (outcomes_seen != lookups_sent) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_MODULE_EN:   cfg_module_en = val[0];
         CSR_CACHE_EN:    cfg_cache_en  = val[0];
         CSR_ENTRY_LIMIT: cfg_limit     = val;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one item, hold it until accepted, then queue its expected result
   task automatic issue_request(input cache_req_type rq, input logic typed,
                                input cache_rsp_type typed_want,
                                output logic [2:0] outcome_status);
      cache_rsp_type want;
      if (idling && $urandom_range(0, 99) < 2) begin
         // hold off until the block has drained
         req_ch.valid <= 1'b0;
         @(posedge clock);
         while (outcomes_seen != lookups_sent) @(posedge clock);
      end else if (idling && $urandom_range(0, 99) < 20) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.req_type   <= rq.req_type;
      req_ch.family     <= rq.family;
      req_ch.addr_high  <= rq.addr_high;
      req_ch.addr_low   <= rq.addr_low;
      req_ch.stat_index <= rq.stat_index;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      want = cache_outcome(rq);
      if (typed) want = typed_want;
      pending_outcomes.push_back(want);
      lookups_sent   = lookups_sent + 1;
      outcome_status = want.status;
   endtask

   // ---------------------------------------------------------------------
   // Result side: random stall bursts while idling is on
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall    <= 0;
      end else if (rsp_stall != 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall    <= rsp_stall - 1;
      end else if (idling && $urandom_range(0, 99) < 12) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall    <= $urandom_range(0, 15);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin : check_outcomes
      cache_rsp_type want;
      if (reset) begin
         outcomes_seen <= 0;
      end else if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("item with nothing outstanding, status",
                            64'(rsp_ch.status), 64'd0);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_ch.status !== want.status)
               report_mismatch("status", 64'(rsp_ch.status), 64'(want.status));
            if (rsp_ch.slot !== want.slot)
               report_mismatch("slot", 64'(rsp_ch.slot), 64'(want.slot));
            if (rsp_ch.distance !== want.distance)
               report_mismatch("distance", 64'(rsp_ch.distance), 64'(want.distance));
            if (rsp_ch.bin_count !== want.bin_count)
               report_mismatch("bin_count", 64'(rsp_ch.bin_count),
                               64'(want.bin_count));
            if (rsp_ch.lookup_count !== want.lookup_count)
               report_mismatch("lookup_count", 64'(rsp_ch.lookup_count),
                               64'(want.lookup_count));
         end
         outcomes_seen <= outcomes_seen + 1;
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                   (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("insertion_order_address_cache_tb failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      stim_row_type row;
      logic [2:0]   st;
      logic [5:0]   lim;
      int unsigned  p, i, counted, quota;

      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= '0;
      csr_wdata         <= '0;
      req_ch.valid      <= 1'b0;
      req_ch.req_type   <= 1'b0;
      req_ch.family     <= '0;
      req_ch.addr_high  <= '0;
      req_ch.addr_low   <= '0;
      req_ch.stat_index <= '0;
      idling            <= 1'b1;
      lookups_sent      = 0;

      // predictor starts from the reset state
      cfg_module_en = 1'b0;
      cfg_cache_en  = 1'b1;
      cfg_limit     = LIMIT_RESET;
      for (i = 0; i < 2; i++) begin
         fill_cnt[i]   = 0;
         ins_pos[i]    = 0;
         search_cnt[i] = '0;
      end
      for (i = 0; i < HBINS; i++) begin
         hit_bins[0][i] = '0;
         hit_bins[1][i] = '0;
      end

      // IPv6 pool: some neighbors share one half, so both halves get compared
      for (i = 0; i < POOL_N; i++) begin
         v4_pool[i]    = $urandom;
         v6_pool_hi[i] = (i % 4 == 1) ? v6_pool_hi[i-1] : rand64();
         v6_pool_lo[i] = (i % 4 == 2) ? v6_pool_lo[i-1] : rand64();
      end

      // Directed table. Typed rows hold results readable without the ring
      // walk; the rest go through the predictor.
      // module disabled: lookups ignored, statistics still answered
      directed_rows.push_back(item_row(REQ_LOOKUP, FAM_V4, 64'd0, 64'h0102_0304, 5'd0,
                                       1'b1, ST_IGNORED, 5'd0, 5'd0));
      directed_rows.push_back(item_row(REQ_STATS, FAM_V4, 64'd0, 64'd0, 5'd0,
                                       1'b1, ST_STATS, 5'd0, 5'd0));
      directed_rows.push_back(item_row(REQ_STATS, FAM_RSV, ONES64, ONES64, 5'd31,
                                       1'b1, ST_STATS, 5'd0, 5'd0));
      directed_rows.push_back(csr_row(CSR_MODULE_EN, 6'd1));
      directed_rows.push_back(csr_row(CSR_ENTRY_LIMIT, 6'd63));
      // unsupported families are ignored
      directed_rows.push_back(item_row(REQ_LOOKUP, FAM_BAD, 64'd0, 64'd0, 5'd31,
                                       1'b1, ST_IGNORED, 5'd0, 5'd0));
      directed_rows.push_back(item_row(REQ_LOOKUP, FAM_RSV, ONES64, ONES64, 5'd31,
                                       1'b1, ST_IGNORED, 5'd0, 5'd0));
      // empty ring: insert at slot 0 without a search; IPv4 ignores upper bits
      directed_rows.push_back(item_row(REQ_LOOKUP, FAM_V4, ONES64, 64'd0, 5'd0,
                                       1'b1, ST_MISS_INS, 5'd0, 5'd0));
      directed_rows.push_back(item_row(REQ_LOOKUP, FAM_V4, 64'd0,
                                       64'hFFFF_FFFF_0000_0000, 5'd0,
                                       1'b1, ST_HIT, 5'd0, 5'd0));
      directed_rows.push_back(item_row(REQ_LOOKUP, FAM_V6, ONES64, ONES64, 5'd0,
                                       1'b1, ST_MISS_INS, 5'd0, 5'd0));
      directed_rows.push_back(item_row(REQ_LOOKUP, FAM_V6, ONES64, 64'd0, 5'd0,
                                       1'b0, ST_IGNORED, 5'd0, 5'd0));
      directed_rows.push_back(item_row(REQ_LOOKUP, FAM_V6, ONES64, ONES64, 5'd0,
                                       1'b0, ST_IGNORED, 5'd0, 5'd0));
      directed_rows.push_back(item_row(REQ_STATS, FAM_V6, 64'd0, 64'd0, 5'd1,
                                       1'b0, ST_IGNORED, 5'd0, 5'd0));
      directed_rows.push_back(item_row(REQ_STATS, FAM_V4, 64'd0, 64'd0, 5'd0,
                                       1'b0, ST_IGNORED, 5'd0, 5'd0));
      // cache disabled: supported lookups go uncached, others stay ignored
      directed_rows.push_back(csr_row(CSR_CACHE_EN, 6'd0));
      directed_rows.push_back(item_row(REQ_LOOKUP, FAM_V4, 64'd0, 64'd0, 5'd0,
                                       1'b1, ST_MISS_UNC, 5'd0, 5'd0));
      directed_rows.push_back(item_row(REQ_LOOKUP, FAM_BAD, 64'd0, 64'd0, 5'd0,
                                       1'b1, ST_IGNORED, 5'd0, 5'd0));
      directed_rows.push_back(item_row(REQ_STATS, FAM_V6, 64'd0, 64'd0, 5'd0,
                                       1'b0, ST_IGNORED, 5'd0, 5'd0));
      directed_rows.push_back(csr_row(CSR_CACHE_EN, 6'd1));
      // limit lowered below the fill: the ring wraps to slot 0
      directed_rows.push_back(csr_row(CSR_ENTRY_LIMIT, 6'd1));
      directed_rows.push_back(item_row(REQ_LOOKUP, FAM_V4, 64'd0, 64'hFFFF_FFFF, 5'd0,
                                       1'b0, ST_IGNORED, 5'd0, 5'd0));
      directed_rows.push_back(item_row(REQ_LOOKUP, FAM_V4, 64'd0, 64'hFFFF_FFFF, 5'd0,
                                       1'b0, ST_IGNORED, 5'd0, 5'd0));
      directed_rows.push_back(item_row(REQ_LOOKUP, FAM_V6, 64'd0, 64'd1, 5'd0,
                                       1'b0, ST_IGNORED, 5'd0, 5'd0));
      // limit zero counts as one; hit found in the wrapped part of the walk
      directed_rows.push_back(csr_row(CSR_ENTRY_LIMIT, 6'd0));
      directed_rows.push_back(item_row(REQ_LOOKUP, FAM_V6, ONES64, 64'd0, 5'd0,
                                       1'b0, ST_IGNORED, 5'd0, 5'd0));
      directed_rows.push_back(item_row(REQ_LOOKUP, FAM_V6, 64'd0, 64'd0, 5'd0,
                                       1'b0, ST_IGNORED, 5'd0, 5'd0));
      // bring the IPv6 ring back to newest == fill so the limit may rise
      directed_rows.push_back(csr_row(CSR_ENTRY_LIMIT, 6'd2));
      directed_rows.push_back(item_row(REQ_LOOKUP, FAM_V6, 64'h8000_0000_0000_0000,
                                       64'd1, 5'd0, 1'b0, ST_IGNORED, 5'd0, 5'd0));
      directed_rows.push_back(csr_row(CSR_ENTRY_LIMIT, 6'd32));
      directed_rows.push_back(item_row(REQ_STATS, FAM_V6, 64'd0, 64'd0, 5'd1,
                                       1'b0, ST_IGNORED, 5'd0, 5'd0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the table
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_CSR) write_reg(row.idx, row.val);
         else issue_request(row.rq, row.typed, row.want, st);
      end

      // Random phases; registers change only between them. The last phase
      // runs with no idling on either side.
      for (p = 0; p < PHASES; p++) begin
         case (p)
            0:       lim = 6'd32;
            1:       lim = 6'd1;
            2:       lim = 6'd0;
            3:       lim = 6'd63;
            5:       lim = 6'($urandom_range(1, 32));
            default: lim = 6'($urandom_range(0, 63));
         endcase
         if (!limit_is_safe(lim)) lim = cfg_limit;
         if (p == PHASES - 1) idling <= 1'b0;
         write_reg(CSR_MODULE_EN, 6'd1);
         write_reg(CSR_CACHE_EN, (p == 4) ? 6'd0 : 6'd1);
         write_reg(CSR_ENTRY_LIMIT, lim);
         quota   = (p == 4) ? UNCACHED_ITEMS : PHASE_ITEMS;
         counted = 0;
         while (counted < quota) begin
            issue_request(draw_request(), 1'b0, '0, st);
            // ignored items do not count toward the phase
            if (st != ST_IGNORED) counted = counted + 1;
         end
      end

      // drain, then give the block time to show any stray result
      req_ch.valid <= 1'b0;
      while (outcomes_seen != lookups_sent) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("insertion_order_address_cache_tb passed");
      end else begin
         $display("insertion_order_address_cache_tb failed");
      end
      $finish;
   end

endmodule
